FILE: hdl/mcfb_pkg.sv
`default_nettype none
package mcfb_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Command codes on the cmd input.
    localparam logic [2:0] CMD_CLEAR_SAFE = 3'd0;
    localparam logic [2:0] CMD_ESTOP      = 3'd1;
    localparam logic [2:0] CMD_READ_VAR   = 3'd2;
    localparam logic [2:0] CMD_SET_SPEED  = 3'd3;
    localparam logic [2:0] CMD_BRAKE      = 3'd4;
    localparam logic [2:0] CMD_FW_QUERY   = 3'd5;

    // Register indexes on the configuration port.
    localparam logic REG_CRC_ENABLE = 1'b0;
    localparam logic REG_MAX_SPEED  = 1'b1;

    // Frame bytes.
    localparam logic [7:0] SYNC_BYTE      = 8'hAA;
    localparam logic [7:0] OP_CLEAR_SAFE  = 8'h03;
    localparam logic [7:0] OP_ESTOP_TAIL  = 8'h60;
    localparam logic [7:0] OP_READ_VAR    = 8'h21;
    localparam logic [7:0] OP_FORWARD     = 8'h05;
    localparam logic [7:0] OP_REVERSE     = 8'h06;
    localparam logic [7:0] OP_BRAKE       = 8'h12;
    localparam logic [7:0] OP_FW_QUERY    = 8'h42;
    localparam logic [7:0] ESTOP_BRAKE    = 8'd37;
    localparam logic [7:0] CRC_POLY       = 8'h91;
    localparam logic [7:0] MAX_SPEED_RST  = 8'hFF;

    // Frame lengths without the check byte.
    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_MID   = 3'd4;
    localparam logic [2:0] LEN_LONG  = 3'd5;

    // One frame to be sent: sync, device, opcode and up to two data bytes.
    typedef struct packed {
        logic [7:0] dev;
        logic [7:0] op;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [2:0] len;
        logic       last_frame;
    } frame_desc_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
    } q_status_t;

    // One byte of the reflected CRC-7, processed LSB first.
    function automatic logic [7:0] crc7_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = c ^ CRC_POLY;
            c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mcfb_queue.sv
`default_nettype none
module mcfb_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mcfb_pkg::frame_desc_t    push_desc,
    input  logic                     pop,
    output mcfb_pkg::frame_desc_t    head_desc,
    output mcfb_pkg::q_status_t      status
);
    import mcfb_pkg::*;

    frame_desc_t      slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    assign head_desc    = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

endmodule
`default_nettype wire

FILE: hdl/mcfb_front.sv
`default_nettype none
module mcfb_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               cmd,
    input  logic [7:0]               device_id,
    input  logic                     direction,
    input  logic [7:0]               speed,
    input  logic [7:0]               brake_amount,
    input  logic [7:0]               variable_id,
    input  logic [7:0]               max_speed,
    input  mcfb_pkg::q_status_t      q_status,
    output logic                     busy,
    output logic                     push,
    output mcfb_pkg::frame_desc_t    push_desc
);
    import mcfb_pkg::*;

    logic        pending_reg;
    frame_desc_t pend_desc_reg;
    frame_desc_t dec_desc;
    frame_desc_t tail_desc;
    logic        dec_valid;
    logic        accept;
    logic [7:0]  clamped;

    // An emergency stop needs two queue slots, so keep one spare.
    assign busy   = pending_reg || (q_status.count >= CNT_W'(FIFO_DEPTH - 1));
    assign accept = start && !busy;

    assign clamped = (speed > max_speed) ? max_speed : speed;

    always_comb
    begin
        dec_valid            = 1'b1;
        dec_desc.dev         = device_id;
        dec_desc.op          = OP_CLEAR_SAFE;
        dec_desc.d0          = 8'h00;
        dec_desc.d1          = 8'h00;
        dec_desc.len         = LEN_SHORT;
        dec_desc.last_frame  = 1'b1;
        tail_desc.dev        = device_id;
        tail_desc.op         = OP_ESTOP_TAIL;
        tail_desc.d0         = 8'h00;
        tail_desc.d1         = 8'h00;
        tail_desc.len        = LEN_SHORT;
        tail_desc.last_frame = 1'b1;
        case (cmd)
            CMD_CLEAR_SAFE:
            begin
                dec_desc.op = OP_CLEAR_SAFE;
            end
            CMD_ESTOP:
            begin
                dec_desc.op         = OP_BRAKE;
                dec_desc.d0         = ESTOP_BRAKE;
                dec_desc.len        = LEN_MID;
                dec_desc.last_frame = 1'b0;
            end
            CMD_READ_VAR:
            begin
                dec_desc.op  = OP_READ_VAR;
                dec_desc.d0  = variable_id;
                dec_desc.len = LEN_MID;
            end
            CMD_SET_SPEED:
            begin
                dec_desc.op  = direction ? OP_FORWARD : OP_REVERSE;
                dec_desc.d1  = clamped;
                dec_desc.len = LEN_LONG;
            end
            CMD_BRAKE:
            begin
                dec_desc.op  = OP_BRAKE;
                dec_desc.d0  = brake_amount;
                dec_desc.len = LEN_MID;
            end
            CMD_FW_QUERY:
            begin
                dec_desc.op = OP_FW_QUERY;
            end
            default:
            begin
                dec_valid = 1'b0;
            end
        endcase
    end

    assign push      = pending_reg || (accept && dec_valid);
    assign push_desc = pending_reg ? pend_desc_reg : dec_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else
            pending_reg <= accept && (cmd == CMD_ESTOP);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_desc_reg <= tail_desc;
    end

endmodule
`default_nettype wire

FILE: hdl/mcfb_back.sv
`default_nettype none
module mcfb_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     crc_enable,
    input  mcfb_pkg::frame_desc_t    head_desc,
    input  mcfb_pkg::q_status_t      q_status,
    output logic                     pop,
    output logic [7:0]               tx_byte,
    output logic                     last,
    output logic                     strobe
);
    import mcfb_pkg::*;

    frame_desc_t desc_reg;
    logic        active_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  crc_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic        strobe_reg;

    logic [7:0]  sel_byte;
    logic [7:0]  cur_byte;
    logic [7:0]  crc_next;
    logic        in_data;
    logic        frame_end;

    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_byte = SYNC_BYTE;
            3'd1:    sel_byte = desc_reg.dev;
            3'd2:    sel_byte = desc_reg.op;
            3'd3:    sel_byte = desc_reg.d0;
            default: sel_byte = desc_reg.d1;
        endcase
    end

    assign in_data   = idx_reg < desc_reg.len;
    assign cur_byte  = in_data ? sel_byte : crc_reg;
    assign crc_next  = crc7_update(crc_reg, sel_byte);
    // The frame ends on its last data byte, or on the check byte after it.
    assign frame_end = active_reg && (crc_enable ? !in_data
                                                 : (idx_reg == desc_reg.len - 3'd1));
    assign pop       = !q_status.empty && (!active_reg || frame_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            strobe_reg <= active_reg;
            last_reg   <= frame_end && desc_reg.last_frame;
            if (pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (frame_end)
                active_reg <= 1'b0;
            else if (active_reg)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg <= cur_byte;
        if (pop)
        begin
            desc_reg <= head_desc;
            crc_reg  <= '0;
        end
        else if (active_reg)
            crc_reg <= crc_next;
    end

    assign tx_byte = tx_byte_reg;
    assign last    = last_reg;
    assign strobe  = strobe_reg;

endmodule
`default_nettype wire

FILE: hdl/motor_command_frame_builder.sv
// Motor command frame builder.
// A command is offered on cmd and its operand ports together with start; it is
// taken at the rising edge where start is high and busy is low. A valid command
// becomes one serial frame (two for an emergency stop): 0xAA, the device byte,
// the opcode and any data bytes, plus a CRC-7 check byte per frame when
// crc_enable is set.
// Bytes leave on tx_byte, one per cycle, each marked by strobe for exactly one
// cycle; last flags the final byte of the command. The receiver cannot stall
// the output, so bytes are never held back once a frame starts.
// When the output side is idle, a taken command is written into the queue,
// popped into the serializer and sent through the output registers. A frame
// holds 3 to 5 bytes plus the check byte, and the serializer loads the next
// frame at the edge that ends the prior one, so queued frames run back to back.
// The decoder and the serializer are split by a four-entry frame queue; busy
// rises while the queue has fewer than two free slots or the second frame of an
// emergency stop is still being queued.
// Reset clears the queue and the serializer; crc_enable resets to 0 and
// max_speed to 255. Registers are written through the APB port at 0 and 4.
`default_nettype none
module motor_command_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    // Command request channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  device_id,
    input  logic        direction,
    input  logic [7:0]  speed,
    input  logic [7:0]  brake_amount,
    input  logic [7:0]  variable_id,
    // Byte output channel
    output logic        strobe,
    output logic [7:0]  tx_byte,
    output logic        last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcfb_pkg::*;

    logic        crc_enable_reg;
    logic [7:0]  max_speed_reg;
    logic        cfg_write;

    logic        push;
    logic        pop;
    frame_desc_t push_desc;
    frame_desc_t head_desc;
    q_status_t   q_status;

    // Register file. The register index is the word address, bit 2 of paddr.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_enable_reg <= 1'b0;
            max_speed_reg  <= MAX_SPEED_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_CRC_ENABLE: crc_enable_reg <= pwdata[0];
                REG_MAX_SPEED:  max_speed_reg  <= pwdata[7:0];
                default:        crc_enable_reg <= crc_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CRC_ENABLE: prdata = {31'd0, crc_enable_reg};
            REG_MAX_SPEED:  prdata = {24'd0, max_speed_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // The front end decodes commands into frame descriptors.
    mcfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .device_id    (device_id),
        .direction    (direction),
        .speed        (speed),
        .brake_amount (brake_amount),
        .variable_id  (variable_id),
        .max_speed    (max_speed_reg),
        .q_status     (q_status),
        .busy         (busy),
        .push         (push),
        .push_desc    (push_desc)
    );

    mcfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    // The back end walks each frame byte by byte and folds in the CRC.
    mcfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .crc_enable (crc_enable_reg),
        .head_desc  (head_desc),
        .q_status   (q_status),
        .pop        (pop),
        .tx_byte    (tx_byte),
        .last       (last),
        .strobe     (strobe)
    );

    // The last flag only ever rides on a valid byte.
    assert property (@(posedge clk) disable iff (!rst_n) last |-> strobe)
        else $error("last without strobe");

    // Bytes of one command leave without gaps.
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && !last) |=> strobe)
        else $error("gap inside a command");

    // An emergency stop blocks the next request while its tail frame is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_ESTOP) |=> (busy && push))
        else $error("emergency stop tail frame not queued");

    // The frame queue never overflows or pops empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.count <= CNT_W'(FIFO_DEPTH)) && !(pop && q_status.empty))
        else $error("frame queue overflow or underflow");

endmodule
`default_nettype wire
